[sv/bfs_pkg.sv]
// Shared types and constants of the breadth-first traversal core.
// Used by the controller, the datapath and the top level.
`default_nettype none

package bfs_pkg;

   localparam int NumVertices = 16;
   localparam int VertexBits  = 4;
   localparam int CountBits   = 5;
   localparam int LabelBits   = 8;
   localparam int PtrBits     = VertexBits + 1;
   localparam logic [CountBits-1:0] CountReset = CountBits'(NumVertices);

   typedef logic [NumVertices-1:0] vmask_type;
   typedef logic [VertexBits-1:0]  vidx_type;

   typedef enum logic [1:0] {
      OP_EDGE  = 2'd0,
      OP_LABEL = 2'd1,
      OP_RUN   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_POP,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic write_edge;
      logic write_label;
      logic clear_run;
      logic emit_start;
      logic pop;
      logic emit_nbr;
   } cmd_type;

   typedef struct packed {
      logic start_avail;
      logic nbr_avail;
      logic queue_empty;
   } status_type;

   // index of the lowest set bit
   function automatic vidx_type lowest_set(input vmask_type m);
      vidx_type idx;
      idx = '0;
      for (int i = NumVertices - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = VertexBits'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

[sv/bfs_adjacency_matrix_traversal_core.sv]
// Breadth-first traversal core over a 16-vertex bit adjacency matrix.
// Request channel: req_start is taken when busy is low. Operation 0 sets or
//   clears the undirected edge vertex_a - vertex_b, operation 1 writes the
//   label of vertex_a, operation 2 starts a run; code 3 is dropped.
//   Edge and label writes complete at the accepting edge and never raise busy.
// A run raises busy the cycle after it is taken and visits every vertex
//   below vertex_count, component by component, lowest unvisited start
//   first, neighbors in index order. Each visit shows on rsp_* for exactly
//   one cycle with rsp_valid high; rsp_last marks the final visit. There is
//   no backpressure: the receiver must take every strobe.
// Sequence: a run is taken into the state register; ST_START emits the
//   lowest unvisited start, and rsp_valid is registered from that emit. Each
//   vertex is emitted once, later dequeued in ST_POP, and its row scanned in
//   ST_SCAN, which emits its unvisited neighbors and then ends the scan.
// Config: csr_data sets vertex_count (saturated to 16) when csr_valid and
//   csr_ready are high; csr_ready is low while a run is in progress.
// Reset (synchronous): clears all edges and labels, sets vertex_count to 16.
// Depends on bfs_pkg, bfs_controller and bfs_datapath.
`default_nettype none

module bfs_adjacency_matrix_traversal_core
   import bfs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_start,
   output logic                       busy,
   input  wire logic [1:0]            req_operation,
   input  wire logic [VertexBits-1:0] req_vertex_a,
   input  wire logic [VertexBits-1:0] req_vertex_b,
   input  wire logic                  req_edge_present,
   input  wire logic [LabelBits-1:0]  req_label_value,
   output logic                       rsp_valid,
   output logic [VertexBits-1:0]      rsp_vertex_index,
   output logic [LabelBits-1:0]       rsp_vertex_label,
   output logic                       rsp_last,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CountBits-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = ~busy;

   bfs_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_start     (req_start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   bfs_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_vertex_a     (req_vertex_a),
      .req_vertex_b     (req_vertex_b),
      .req_edge_present (req_edge_present),
      .req_label_value  (req_label_value),
      .csr_write        (csr_valid & csr_ready),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_vertex_label (rsp_vertex_label),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result strobe right after last");

   a_run_goes_busy: assert property (@(posedge clock) disable iff (reset)
      req_start && !busy && (req_operation == OP_RUN) |=> busy)
      else $error("run accepted but core not busy");

   a_result_in_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe outside a run");
`endif

endmodule

`default_nettype wire

[sv/bfs_controller.sv]
// Sequencer of the traversal core: decodes requests and steps a run.
// Depends on bfs_pkg; drives commands to bfs_datapath.
`default_nettype none

module bfs_controller
   import bfs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_start,
   input  wire logic [1:0] req_operation,
   input  status_type      status,
   output cmd_type         cmd,
   output logic            busy
);

   state_type state_ff, state_in;
   op_type    op;

   assign op   = op_type'(req_operation);
   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               unique case (op)
                  OP_EDGE:  cmd.write_edge = 1'b1;
                  OP_LABEL: cmd.write_label = 1'b1;
                  OP_RUN: begin
                     cmd.clear_run = 1'b1;
                     state_in      = ST_START;
                  end
                  default: ;
               endcase
            end
         end
         ST_START: begin
            if (status.start_avail) begin
               cmd.emit_start = 1'b1;
               state_in       = ST_POP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.nbr_avail) begin
               cmd.emit_nbr = 1'b1;
            end else if (!status.queue_empty) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_START;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

[sv/bfs_datapath.sv]
// Graph store, visited mask, vertex queue and result register.
// Depends on bfs_pkg; controlled by bfs_controller.
`default_nettype none

module bfs_datapath
   import bfs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  wire logic [VertexBits-1:0] req_vertex_a,
   input  wire logic [VertexBits-1:0] req_vertex_b,
   input  wire logic                 req_edge_present,
   input  wire logic [LabelBits-1:0] req_label_value,
   input  wire logic                 csr_write,
   input  wire logic [CountBits-1:0] csr_data,
   output logic                      rsp_valid,
   output logic [VertexBits-1:0]     rsp_vertex_index,
   output logic [LabelBits-1:0]      rsp_vertex_label,
   output logic                      rsp_last
);

   vmask_type               adj_ff [NumVertices];
   logic [LabelBits-1:0]    label_ff [NumVertices];
   vidx_type                fifo_ff [NumVertices];
   vmask_type               visited_ff;
   vmask_type               row_ff;
   logic [PtrBits-1:0]      head_ff, tail_ff;
   logic [CountBits-1:0]    count_ff;
   logic                    valid_ff;
   vidx_type                index_ff;
   logic [LabelBits-1:0]    vlabel_ff;
   logic                    last_ff;

   vmask_type count_mask;
   vmask_type unvisited;
   vmask_type cand;
   vmask_type visited_in;
   vidx_type  start_idx, nbr_idx, emit_idx;
   logic      emit;

   always_comb begin
      for (int i = 0; i < NumVertices; i++) begin
         count_mask[i] = (CountBits'(i) < count_ff);
      end
   end

   assign unvisited  = ~visited_ff & count_mask;
   assign cand       = row_ff & ~visited_ff;
   assign start_idx  = lowest_set(unvisited);
   assign nbr_idx    = lowest_set(cand);
   assign emit       = cmd.emit_start | cmd.emit_nbr;
   assign emit_idx   = cmd.emit_start ? start_idx : nbr_idx;
   assign visited_in = visited_ff | (vmask_type'(1) << emit_idx);

   assign status.start_avail = |unvisited;
   assign status.nbr_avail   = |cand;
   assign status.queue_empty = (head_ff == tail_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumVertices; i++) begin
            adj_ff[i]   <= '0;
            label_ff[i] <= '0;
         end
         count_ff   <= CountReset;
         visited_ff <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= emit;
         if (csr_write) begin
            count_ff <= (csr_data > CountReset) ? CountReset : csr_data;
         end
         if (cmd.write_edge) begin
            adj_ff[req_vertex_a][req_vertex_b] <= req_edge_present;
            adj_ff[req_vertex_b][req_vertex_a] <= req_edge_present;
         end
         if (cmd.write_label) begin
            label_ff[req_vertex_a] <= req_label_value;
         end
         if (cmd.clear_run) begin
            visited_ff <= '0;
            head_ff    <= '0;
            tail_ff    <= '0;
         end
         if (emit) begin
            visited_ff <= visited_in;
            tail_ff    <= tail_ff + PtrBits'(1);
         end
         if (cmd.pop) begin
            head_ff <= head_ff + PtrBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         fifo_ff[tail_ff[VertexBits-1:0]] <= emit_idx;
         index_ff  <= emit_idx;
         vlabel_ff <= label_ff[emit_idx];
         last_ff   <= (visited_in == count_mask);
      end
      if (cmd.pop) begin
         row_ff <= adj_ff[fifo_ff[head_ff[VertexBits-1:0]]] & count_mask;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_vertex_index = index_ff;
   assign rsp_vertex_label = vlabel_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire
